/* hw/rtl/thl_pkg.sv */
// Shared types and constants for the takeoff, hover and land sequencer.
// Used by thl_div, the top level and the checker; depends on nothing.
package thl_pkg;

    // Phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_ARMING  = 3'd1;
    localparam logic [2:0] PH_DWELL   = 3'd2;
    localparam logic [2:0] PH_TAKEOFF = 3'd3;
    localparam logic [2:0] PH_HOVER   = 3'd4;
    localparam logic [2:0] PH_LAND    = 3'd5;

    // Setpoint modes
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_POS  = 2'd1;
    localparam logic [1:0] MODE_VEL  = 2'd2;

    // Arm requests
    localparam logic [1:0] AREQ_NONE   = 2'd0;
    localparam logic [1:0] AREQ_ARM    = 2'd1;
    localparam logic [1:0] AREQ_DISARM = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_ARM_TIMEOUT = 3'd0;
    localparam logic [2:0] CFG_DWELL       = 3'd1;
    localparam logic [2:0] CFG_TAKEOFF     = 3'd2;
    localparam logic [2:0] CFG_HOVER       = 3'd3;
    localparam logic [2:0] CFG_LAND_LIMIT  = 3'd4;
    localparam logic [2:0] CFG_TARGET      = 3'd5;
    localparam logic [2:0] CFG_DESCENT     = 3'd6;
    localparam logic [2:0] CFG_CUTOFF      = 3'd7;

    // Ramp division: 12-bit height times 16-bit tick count
    localparam int PROD_W = 28;
    localparam int DVSR_W = 16;
    localparam int QUO_W  = 12;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic               enable_now;
        logic               height_reached;
        logic [2:0]         phase;
        logic [1:0]         arm_request;
        logic signed [10:0] sp_vz_mm_s;
        logic [11:0]        sp_z_mm;
        logic signed [15:0] sp_y_mm;
        logic signed [15:0] sp_x_mm;
        logic [1:0]         setpoint_mode;
    } t_result;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* hw/rtl/takeoff_hover_land_sequencer_core.sv */
// Channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | one control tick (56-bit tdata)
// m_axis    | out | m_axis_tvalid/m_axis_tready  | one setpoint (64-bit tdata)
// cfg       | in  | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// An accepted tick passes an evaluate step and an emit step; takeoff ramp
// ticks also pass a divide step between them, run by the bit-serial divider.
// Reset is synchronous and active low; it restores the register defaults.
// The next tick is accepted while a result still waits; if m_axis stalls,
// that tick waits in its final step until the output register frees up.
// Holds the phase sequencer; depends on thl_pkg and thl_div.
module takeoff_hover_land_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // is_armed, deck_present, tumbled, est_x_mm, est_y_mm, est_z_mm,
    // enable_set, enable_clear, then three zero bits
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // setpoint_mode, sp_x_mm, sp_y_mm, sp_z_mm, sp_vz_mm_s, arm_request,
    // phase, height_reached, enable_now
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_EMIT} t_state;

    // Configuration
    logic [15:0] r_arm_to, r_dwell, r_takeoff, r_hover, r_land_lim;
    logic [11:0] r_target;
    logic [9:0]  r_descent, r_cutoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_to   <= 16'd150;
            r_dwell    <= 16'd150;
            r_takeoff  <= 16'd100;
            r_hover    <= 16'd150;
            r_land_lim <= 16'd250;
            r_target   <= 12'd500;
            r_descent  <= 10'd150;
            r_cutoff   <= 10'd50;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                thl_pkg::CFG_ARM_TIMEOUT: r_arm_to   <= i_cfg_data;
                thl_pkg::CFG_DWELL:       r_dwell    <= i_cfg_data;
                thl_pkg::CFG_TAKEOFF:     r_takeoff  <= i_cfg_data;
                thl_pkg::CFG_HOVER:       r_hover    <= i_cfg_data;
                thl_pkg::CFG_LAND_LIMIT:  r_land_lim <= i_cfg_data;
                thl_pkg::CFG_TARGET:      r_target   <= i_cfg_data[11:0];
                thl_pkg::CFG_DESCENT:     r_descent  <= i_cfg_data[9:0];
                thl_pkg::CFG_CUTOFF:      r_cutoff   <= i_cfg_data[9:0];
                default:                  r_cutoff   <= r_cutoff;
            endcase
        end
    end

    // Captured tick
    logic        r_armed, r_deck, r_tumble, r_set, r_clear;
    logic [15:0] r_ex, r_ey;
    logic signed [15:0] r_ez;

    // Sequencer state
    t_state      r_state;
    logic [2:0]  r_phase;
    logic [15:0] r_tip;
    logic        r_en, r_reached;
    logic [15:0] r_hold_x, r_hold_y, r_land_x, r_land_y;
    thl_pkg::t_result r_res, r_out;
    logic        r_out_valid;

    // Next-state and result of the evaluation step
    logic [2:0]  n_phase;
    logic [15:0] n_tip;
    logic        n_en, n_reached;
    logic [15:0] n_hold_x, n_hold_y, n_land_x, n_land_y;
    thl_pkg::t_result n_res;
    logic        need_div;
    logic        en1;
    logic [15:0] el;

    logic [thl_pkg::QUO_W-1:0] quotient;
    thl_pkg::t_div_stat        div_stat;
    logic                      div_start;
    logic [thl_pkg::PROD_W-1:0] product;

    always_comb begin
        en1 = r_clear ? 1'b0 : (r_set ? 1'b1 : r_en);
        el  = (r_tip == 16'hFFFF) ? r_tip : r_tip + 16'd1;

        n_phase   = r_phase;
        n_tip     = el;
        n_en      = en1;
        n_reached = r_reached;
        n_hold_x  = r_hold_x;
        n_hold_y  = r_hold_y;
        n_land_x  = r_land_x;
        n_land_y  = r_land_y;
        need_div  = 1'b0;
        n_res     = '0;

        if (r_tumble && r_phase >= thl_pkg::PH_DWELL && r_phase <= thl_pkg::PH_LAND) begin
            n_res.arm_request = thl_pkg::AREQ_DISARM;
            n_en      = 1'b0;
            n_reached = 1'b0;
            n_phase   = thl_pkg::PH_IDLE;
            n_tip     = '0;
        end else begin
            unique case (r_phase) inside
                thl_pkg::PH_ARMING: begin
                    if (!en1) begin
                        n_phase = thl_pkg::PH_IDLE;
                        n_tip   = '0;
                    end else if (r_armed) begin
                        n_phase = thl_pkg::PH_DWELL;
                        n_tip   = '0;
                    end else if (el > r_arm_to) begin
                        n_en    = 1'b0;
                        n_phase = thl_pkg::PH_IDLE;
                        n_tip   = '0;
                    end else begin
                        n_res.arm_request = thl_pkg::AREQ_ARM;
                    end
                end
                thl_pkg::PH_DWELL: begin
                    if (!en1) begin
                        n_res.arm_request = thl_pkg::AREQ_DISARM;
                        n_phase = thl_pkg::PH_IDLE;
                        n_tip   = '0;
                    end else if (!r_armed) begin
                        n_phase = thl_pkg::PH_ARMING;
                        n_tip   = '0;
                    end else if (el >= r_dwell) begin
                        n_hold_x = r_ex;
                        n_hold_y = r_ey;
                        n_phase  = thl_pkg::PH_TAKEOFF;
                        n_tip    = '0;
                    end
                end
                thl_pkg::PH_TAKEOFF, thl_pkg::PH_HOVER: begin
                    if (!en1) begin
                        // Abort: descend from where the vehicle is now.
                        n_land_x = r_ex;
                        n_land_y = r_ey;
                        n_phase  = thl_pkg::PH_LAND;
                        n_tip    = '0;
                        n_res.setpoint_mode = thl_pkg::MODE_VEL;
                        n_res.sp_x_mm       = r_ex;
                        n_res.sp_y_mm       = r_ey;
                        n_res.sp_vz_mm_s    = 11'(11'd0 - {1'b0, r_descent});
                    end else begin
                        n_res.setpoint_mode = thl_pkg::MODE_POS;
                        n_res.sp_x_mm       = r_hold_x;
                        n_res.sp_y_mm       = r_hold_y;
                        if (r_phase == thl_pkg::PH_TAKEOFF) begin
                            if (el >= r_takeoff) begin
                                n_res.sp_z_mm = r_target;
                                n_reached     = 1'b1;
                                n_phase       = thl_pkg::PH_HOVER;
                                n_tip         = '0;
                            end else begin
                                need_div = 1'b1;
                            end
                        end else begin
                            n_res.sp_z_mm = r_target;
                            if (el >= r_hover) begin
                                n_land_x = r_hold_x;
                                n_land_y = r_hold_y;
                                n_phase  = thl_pkg::PH_LAND;
                                n_tip    = '0;
                            end
                        end
                    end
                end
                thl_pkg::PH_LAND: begin
                    if (r_ez > $signed({6'd0, r_cutoff}) && el < r_land_lim) begin
                        n_res.setpoint_mode = thl_pkg::MODE_VEL;
                        n_res.sp_x_mm       = r_land_x;
                        n_res.sp_y_mm       = r_land_y;
                        n_res.sp_vz_mm_s    = 11'(11'd0 - {1'b0, r_descent});
                    end else begin
                        n_res.arm_request = thl_pkg::AREQ_DISARM;
                        n_reached = 1'b0;
                        n_en      = 1'b0;
                        n_phase   = thl_pkg::PH_IDLE;
                        n_tip     = '0;
                    end
                end
                default: begin
                    // Idle, and any code outside the phase list behaves as idle.
                    if (r_phase != thl_pkg::PH_IDLE) begin
                        n_phase = thl_pkg::PH_IDLE;
                        n_tip   = '0;
                    end
                    n_reached = 1'b0;
                    if (en1 && r_deck) begin
                        n_phase = thl_pkg::PH_ARMING;
                        n_tip   = '0;
                    end
                end
            endcase
        end

        n_res.phase          = n_phase;
        n_res.height_reached = n_reached;
        n_res.enable_now     = n_en;
    end

    assign div_start = (r_state == S_EVAL) && need_div;
    assign product   = {16'd0, r_target} * {12'd0, el};

    thl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_takeoff),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= thl_pkg::PH_IDLE;
            r_tip       <= '0;
            r_en        <= 1'b1;
            r_reached   <= 1'b0;
            r_hold_x    <= '0;
            r_hold_y    <= '0;
            r_land_x    <= '0;
            r_land_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // In the emit step the output register is refilled instead.
            if (r_out_valid && m_axis_tready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_armed  <= s_axis_tdata[0];
                        r_deck   <= s_axis_tdata[1];
                        r_tumble <= s_axis_tdata[2];
                        r_ex     <= s_axis_tdata[18:3];
                        r_ey     <= s_axis_tdata[34:19];
                        r_ez     <= s_axis_tdata[50:35];
                        r_set    <= s_axis_tdata[51];
                        r_clear  <= s_axis_tdata[52];
                        r_state  <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_phase   <= n_phase;
                    r_tip     <= n_tip;
                    r_en      <= n_en;
                    r_reached <= n_reached;
                    r_hold_x  <= n_hold_x;
                    r_hold_y  <= n_hold_y;
                    r_land_x  <= n_land_x;
                    r_land_y  <= n_land_y;
                    r_res     <= n_res;
                    r_state   <= need_div ? S_DIV : S_EMIT;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_res.sp_z_mm <= quotient;
                        r_state       <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

/* hw/rtl/thl_div.sv */
// Bit-serial restoring divider for the takeoff height ramp.
// One quotient bit per cycle; uses thl_pkg for widths and the status struct.
module thl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [thl_pkg::PROD_W-1:0]    i_dividend,
    input  logic [thl_pkg::DVSR_W-1:0]    i_divisor,
    output logic [thl_pkg::QUO_W-1:0]     o_quotient,
    output thl_pkg::t_div_stat            o_stat
);

    logic [thl_pkg::DVSR_W-1:0] r_rem;
    logic [thl_pkg::PROD_W-1:0] r_quo;
    logic [4:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [thl_pkg::DVSR_W:0]   trial;
    logic                       fits;

    // The shift register holds the dividend bits still to come in its upper
    // part and the quotient bits found so far in its lower part.
    assign trial = {r_rem, r_quo[thl_pkg::PROD_W-1]};
    assign fits  = (trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(thl_pkg::PROD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= fits ? thl_pkg::DVSR_W'(trial - {1'b0, i_divisor})
                              : trial[thl_pkg::DVSR_W-1:0];
                r_quo <= {r_quo[thl_pkg::PROD_W-2:0], fits};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // The ramp only divides while the tick count is below the divisor, so the
    // quotient stays below the target height.
    assign o_quotient  = r_quo[thl_pkg::QUO_W-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

/* hw/rtl/thl_chk.sv */
// Port-level checker for the sequencer core, attached by the bind below.
// Uses thl_pkg for the mode and arm request codes.
module thl_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    logic [1:0] mode;
    assign mode = m_axis_tdata[1:0];

    // A tick is worked on alone: the input closes in the cycle after a word is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input still open the cycle after a word was taken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed or vanished");

    // A stop setpoint carries no position or velocity.
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && mode == thl_pkg::MODE_STOP |->
            m_axis_tdata[56:2] == '0)
        else $error("stop setpoint with non-zero fields");

    // A descent setpoint has no height and no arm request.
    a_vel_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && mode == thl_pkg::MODE_VEL |->
            m_axis_tdata[45:34] == '0 && m_axis_tdata[58:57] == thl_pkg::AREQ_NONE)
        else $error("descent setpoint with height or arm request");

endmodule

bind takeoff_hover_land_sequencer_core thl_chk u_thl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/thl_setpoint_checker.sv */
// Setpoint checker for the takeoff, hover and land sequencer: watches the tick,
// setpoint and register-write channels, predicts each setpoint and compares.
// Depends on thl_pkg for the phase, mode, request and register codes.
`timescale 1ns / 1ps

module thl_setpoint_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    // Shadow of the register file
    int arm_to, dwell_len, takeoff_len, hover_len, land_lim;
    int target_h, sink_rate, cutoff_h;

    // Shadow of the sequencer state
    logic [2:0]  ph;
    int          ticks;
    logic        en, reached;
    logic [15:0] hx, hy, lx, ly;

    thl_pkg::t_result setpoint_due[$];
    int      mismatches = 0;

    function automatic void enter(input logic [2:0] next_ph);
        ph    = next_ph;
        ticks = 0;
    endfunction

    function automatic thl_pkg::t_result next_setpoint(input logic [55:0] w);
        logic        armed, deck, tumble;
        logic [15:0] ex, ey;
        int          ez, el;
        thl_pkg::t_result r;
        armed  = w[0];
        deck   = w[1];
        tumble = w[2];
        ex     = w[18:3];
        ey     = w[34:19];
        ez     = $signed(w[50:35]);
        r      = '0;
        r.setpoint_mode = thl_pkg::MODE_STOP;
        r.arm_request   = thl_pkg::AREQ_NONE;

        // A clear request wins over a set request.
        if (w[52])
            en = 1'b0;
        else if (w[51])
            en = 1'b1;
        if (ticks < 65535)
            ticks++;
        el = ticks;

        if (tumble && ph >= thl_pkg::PH_DWELL && ph <= thl_pkg::PH_LAND) begin
            r.arm_request = thl_pkg::AREQ_DISARM;
            en      = 1'b0;
            reached = 1'b0;
            enter(thl_pkg::PH_IDLE);
        end else begin
            case (ph)
                thl_pkg::PH_ARMING: begin
                    if (!en)
                        enter(thl_pkg::PH_IDLE);
                    else if (armed)
                        enter(thl_pkg::PH_DWELL);
                    else if (el > arm_to) begin
                        en = 1'b0;
                        enter(thl_pkg::PH_IDLE);
                    end else
                        r.arm_request = thl_pkg::AREQ_ARM;
                end
                thl_pkg::PH_DWELL: begin
                    if (!en) begin
                        r.arm_request = thl_pkg::AREQ_DISARM;
                        enter(thl_pkg::PH_IDLE);
                    end else if (!armed)
                        enter(thl_pkg::PH_ARMING);
                    else if (el >= dwell_len) begin
                        hx = ex;
                        hy = ey;
                        enter(thl_pkg::PH_TAKEOFF);
                    end
                end
                thl_pkg::PH_TAKEOFF, thl_pkg::PH_HOVER: begin
                    if (!en) begin
                        // Abort: descend from where the vehicle is now.
                        lx = ex;
                        ly = ey;
                        enter(thl_pkg::PH_LAND);
                        r.setpoint_mode = thl_pkg::MODE_VEL;
                        r.sp_x_mm       = lx;
                        r.sp_y_mm       = ly;
                        r.sp_vz_mm_s    = -11'(sink_rate);
                    end else begin
                        r.setpoint_mode = thl_pkg::MODE_POS;
                        r.sp_x_mm       = hx;
                        r.sp_y_mm       = hy;
                        if (ph == thl_pkg::PH_TAKEOFF) begin
                            if (el >= takeoff_len) begin
                                r.sp_z_mm = 12'(target_h);
                                reached   = 1'b1;
                                enter(thl_pkg::PH_HOVER);
                            end else
                                r.sp_z_mm = 12'(target_h * el / takeoff_len);
                        end else begin
                            r.sp_z_mm = 12'(target_h);
                            if (el >= hover_len) begin
                                lx = hx;
                                ly = hy;
                                enter(thl_pkg::PH_LAND);
                            end
                        end
                    end
                end
                thl_pkg::PH_LAND: begin
                    if (ez > cutoff_h && el < land_lim) begin
                        r.setpoint_mode = thl_pkg::MODE_VEL;
                        r.sp_x_mm       = lx;
                        r.sp_y_mm       = ly;
                        r.sp_vz_mm_s    = -11'(sink_rate);
                    end else begin
                        r.arm_request = thl_pkg::AREQ_DISARM;
                        reached = 1'b0;
                        en      = 1'b0;
                        enter(thl_pkg::PH_IDLE);
                    end
                end
                default: begin
                    // Idle keeps counting; an unknown code falls back to idle.
                    if (ph != thl_pkg::PH_IDLE)
                        enter(thl_pkg::PH_IDLE);
                    reached = 1'b0;
                    if (en && deck)
                        enter(thl_pkg::PH_ARMING);
                end
            endcase
        end

        r.phase          = ph;
        r.height_reached = reached;
        r.enable_now     = en;
        return r;
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t setpoint %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        thl_pkg::t_result want, got;
        if (!i_rst_n) begin
            arm_to      = 150;
            dwell_len   = 150;
            takeoff_len = 100;
            hover_len   = 150;
            land_lim    = 250;
            target_h    = 500;
            sink_rate   = 150;
            cutoff_h    = 50;
            ph          = thl_pkg::PH_IDLE;
            ticks       = 0;
            en          = 1'b1;
            reached     = 1'b0;
            hx = '0; hy = '0; lx = '0; ly = '0;
            setpoint_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    thl_pkg::CFG_ARM_TIMEOUT: arm_to      = i_cfg_data;
                    thl_pkg::CFG_DWELL:       dwell_len   = i_cfg_data;
                    thl_pkg::CFG_TAKEOFF:     takeoff_len = i_cfg_data;
                    thl_pkg::CFG_HOVER:       hover_len   = i_cfg_data;
                    thl_pkg::CFG_LAND_LIMIT:  land_lim    = i_cfg_data;
                    thl_pkg::CFG_TARGET:      target_h    = i_cfg_data[11:0];
                    thl_pkg::CFG_DESCENT:     sink_rate   = i_cfg_data[9:0];
                    thl_pkg::CFG_CUTOFF:      cutoff_h    = i_cfg_data[9:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = thl_pkg::t_result'(m_axis_tdata);
                if (setpoint_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t setpoint word %h arrived with none outstanding",
                                 $realtime, m_axis_tdata);
                end else begin
                    want = setpoint_due.pop_front();
                    check_field("mode", want.setpoint_mode, got.setpoint_mode);
                    check_field("x", want.sp_x_mm, got.sp_x_mm);
                    check_field("y", want.sp_y_mm, got.sp_y_mm);
                    check_field("z", want.sp_z_mm, got.sp_z_mm);
                    check_field("vz", want.sp_vz_mm_s, got.sp_vz_mm_s);
                    check_field("arm_request", want.arm_request, got.arm_request);
                    check_field("phase", want.phase, got.phase);
                    check_field("height_reached", want.height_reached, got.height_reached);
                    check_field("enable_now", want.enable_now, got.enable_now);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                setpoint_due.push_back(next_setpoint(s_axis_tdata));
        end
        o_fail_count <= mismatches;
        o_pending    <= setpoint_due.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the sequencer testbench: clock, reset, tick stimulus, output pacing,
// register programming and the verdict. Depends on thl_pkg, the sequencer core
// and thl_setpoint_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    // is_armed, deck_present, tumbled, est_x_mm, est_y_mm, est_z_mm,
    // enable_set, enable_clear, then three zero bits
    logic [55:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // setpoint_mode, sp_x_mm, sp_y_mm, sp_z_mm, sp_vz_mm_s, arm_request,
    // phase, height_reached, enable_now
    wire  [63:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = thl_pkg::CFG_ARM_TIMEOUT;
    logic [15:0] i_cfg_data = '0;

    int fails, pending;
    int idle_cycles = 0;
    int rdy_hold = 0;
    int rx_pick;
    bit quiet = 1'b0;
    int p_armed = 97, p_deck = 90, p_tumble = 0, p_clear = 2, p_set = 20;

    takeoff_hover_land_sequencer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    thl_setpoint_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fails),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Output side pacing: mostly short stalls, now and then a long one.
    always @(posedge i_clk) begin
        if (rdy_hold > 0)
            rdy_hold--;
        else if (quiet)
            m_axis_tready <= 1'b1;
        else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 60) begin
                m_axis_tready <= 1'b1;
                rdy_hold = $urandom_range(0, 6);
            end else if (rx_pick < 94) begin
                m_axis_tready <= 1'b0;
                rdy_hold = $urandom_range(0, 2);
            end else begin
                m_axis_tready <= 1'b0;
                rdy_hold = $urandom_range(10, 40);
            end
        end
    end

    // Ends the run if no word moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [55:0] pack_tick(input logic armed, deck, tumble,
                                              input logic [15:0] x, y, z,
                                              input logic set_req, clr_req);
        return {3'b000, clr_req, set_req, z, y, x, tumble, deck, armed};
    endfunction

    function automatic logic [55:0] random_tick();
        logic [15:0] x, y, z;
        x = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400)) - 16'd200;
        y = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 400)) - 16'd200;
        case ($urandom_range(0, 9))
            0, 1:    z = 16'($urandom);
            2:       z = 16'($urandom_range(0, 60));
            default: z = 16'($urandom_range(0, 1500));
        endcase
        return pack_tick($urandom_range(0, 99) < p_armed, $urandom_range(0, 99) < p_deck,
                         $urandom_range(0, 99) < p_tumble, x, y, z,
                         $urandom_range(0, 99) < p_set, $urandom_range(0, 99) < p_clear);
    endfunction

    // Presents one word after an optional gap and returns at the edge that takes it.
    task automatic send_tick(input logic [55:0] word, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic load_config(input logic [15:0] arm_to, dwell_len, takeoff_len, hover_len,
                               input logic [15:0] land_lim, target_h, sink_rate, cutoff_h);
        logic [15:0] vals [8];
        vals[thl_pkg::CFG_ARM_TIMEOUT] = arm_to;
        vals[thl_pkg::CFG_DWELL]       = dwell_len;
        vals[thl_pkg::CFG_TAKEOFF]     = takeoff_len;
        vals[thl_pkg::CFG_HOVER]       = hover_len;
        vals[thl_pkg::CFG_LAND_LIMIT]  = land_lim;
        vals[thl_pkg::CFG_TARGET]      = target_h;
        vals[thl_pkg::CFG_DESCENT]     = sink_rate;
        vals[thl_pkg::CFG_CUTOFF]      = cutoff_h;
        drain();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= 3'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int count);
        int gap, pick;
        for (int n = 0; n < count; n++) begin
            // A fresh behaviour profile every forty words keeps flights going
            // while still hitting timeouts, aborts and tumbles.
            if (n % 40 == 0) begin
                pick     = $urandom_range(0, 5);
                p_armed  = (pick < 4) ? 97 : (pick == 4) ? 60 : 10;
                pick     = $urandom_range(0, 2);
                p_tumble = (pick == 0) ? 0 : (pick == 1) ? 1 : 8;
                pick     = $urandom_range(0, 2);
                p_clear  = (pick == 0) ? 0 : (pick == 1) ? 2 : 15;
                p_set    = $urandom_range(0, 1) ? 20 : 60;
                p_deck   = 90;
                quiet    = ($urandom_range(0, 4) == 0);
            end
            if ($urandom_range(0, 149) == 0)
                drain();
            if (quiet)
                gap = 0;
            else begin
                pick = $urandom_range(0, 99);
                gap = (pick < 65) ? 0 : (pick < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
            end
            send_tick(random_tick(), gap);
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: idle without deck, arming, clear beating set in dwell,
        // arming abandoned, tumble ignored while arming and taken in dwell.
        send_tick(pack_tick(0, 0, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'h8000, 16'h7FFF, 16'h8000, 0, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'hFFFF, 16'h0001, 16'hFFFF, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, 1), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 1), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, 0), 0);
        send_tick(pack_tick(1, 1, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);

        // Short timings: arming timeout, full flight, descent down to the
        // cutoff, then an abort mid-ramp and a tumble while landing.
        load_config(16'd1, 16'd1, 16'd3, 16'd2, 16'd3, 16'd4000, 16'd1000, 16'd1000);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h7FFF, 16'h8000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h7FFF, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'd1000, 0, 0), 0);
        send_tick(pack_tick(0, 1, 0, 16'h0000, 16'h0000, 16'h0000, 1, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h0000, 16'h0000, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h1234, 16'hEDCB, 16'h0000, 0, 0), 0);
        send_tick(pack_tick(1, 1, 0, 16'h8001, 16'h7FFE, 16'd2000, 0, 1), 0);
        send_tick(pack_tick(1, 1, 1, 16'h0000, 16'h0000, 16'd2000, 0, 0), 0);
        run_phase(150);

        load_config(16'd150, 16'd150, 16'd100, 16'd150, 16'd250, 16'd500, 16'd150, 16'd50);
        run_phase(300);
        load_config(16'd4, 16'd3, 16'd7, 16'd5, 16'd10, 16'd1234, 16'd321, 16'd100);
        run_phase(350);
        load_config(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_phase(200);
        load_config(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd4000, 16'd1000,
                    16'd1000);
        run_phase(200);
        // A ramp length of zero finishes the takeoff on its first tick.
        load_config(16'd2, 16'd2, 16'd0, 16'd3, 16'd5, 16'd4000, 16'd1000, 16'd1000);
        run_phase(150);
        repeat (3) begin
            load_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
                        16'($urandom_range(1, 12)), 16'($urandom_range(0, 8)),
                        16'($urandom_range(0, 12)), 16'($urandom_range(0, 4000)),
                        16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)));
            run_phase(150);
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
